// ----- rtl/core/vgpl_pkg.sv -----
// Shared types and constants of the voxel grid point limiter.
`default_nettype none

package vgpl_pkg;

    // One input beat: a point in signed Q16.16 metres.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_beat;

    // One output beat: the decision for one point.
    typedef struct packed {
        logic       keep;
        logic       table_overflow;
        logic [7:0] voxel_count;
    } t_out_beat;

    // Voxel key: three saturated 21-bit indices, x in the top bits.
    typedef struct packed {
        logic [20:0] x;
        logic [20:0] y;
        logic [20:0] z;
    } t_voxel_key;

    // Configuration register indexes.
    localparam logic [7:0] CFG_INV_VOXEL_SIZE = 8'd0;
    localparam logic [7:0] CFG_MAX_POINTS     = 8'd1;

    localparam logic [31:0] INV_VOXEL_SIZE_RST = 32'd655360;
    localparam logic [7:0]  MAX_POINTS_RST     = 8'd1;

    // Saturation limits of a voxel index.
    localparam logic signed [31:0] IDX_MAX = 32'sd1048575;
    localparam logic signed [31:0] IDX_MIN = -32'sd1048576;

    // Spatial hash multipliers.
    localparam logic [31:0] HASH_X = 32'd73856093;
    localparam logic [31:0] HASH_Y = 32'd19349663;
    localparam logic [31:0] HASH_Z = 32'd83492791;

    // Result queue sizing.
    localparam int RES_FIFO_DEPTH = 16;
    localparam int RES_FIFO_PTR_W = 4;
    localparam int RES_FIFO_CNT_W = 5;

endpackage

`default_nettype wire

// ----- rtl/core/vgpl_front.sv -----
// Quantization, spatial hash and set reduction pipeline of the point limiter.
`default_nettype none

module vgpl_front #(
    parameter int TABLE_SETS = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire vgpl_pkg::t_in_beat    i_pos,
    input  wire logic [31:0]           i_inv_size,
    output logic                       o_valid,
    output logic [$clog2(TABLE_SETS)-1:0] o_set,
    output vgpl_pkg::t_voxel_key       o_key
);
    import vgpl_pkg::*;

    localparam int SET_W = $clog2(TABLE_SETS);
    // Reciprocal for an exact h / TABLE_SETS on 32-bit h.
    localparam logic [63:0] RECIP_WIDE = ((64'd1 << (32 + SET_W)) / 64'(TABLE_SETS)) + 64'd1;
    localparam logic [32:0] RECIP = RECIP_WIDE[32:0];

    function automatic logic [20:0] sat_index(input logic signed [31:0] q);
        logic [20:0] res;
        if (q > IDX_MAX) begin
            res = IDX_MAX[20:0];
        end else if (q < IDX_MIN) begin
            res = IDX_MIN[20:0];
        end else begin
            res = q[20:0];
        end
        return res;
    endfunction

    logic signed [64:0] n1_p [3];
    logic signed [63:0] r1_p [3];
    logic               r1_valid;

    t_voxel_key  r2_key;
    logic        r2_valid;

    logic [31:0] r3_hx, r3_hy, r3_hz;
    t_voxel_key  r3_key;
    logic        r3_valid;

    logic [31:0] n4_h;
    logic [64:0] n4_prod;
    logic [31:0] r4_h, r4_q;
    t_voxel_key  r4_key;
    logic        r4_valid;

    logic [31:0] n5_rem;
    logic [SET_W-1:0] r5_set;
    t_voxel_key  r5_key;
    logic        r5_valid;

    always_comb begin
        n1_p[0] = $signed(i_pos.pos_x) * $signed({1'b0, i_inv_size});
        n1_p[1] = $signed(i_pos.pos_y) * $signed({1'b0, i_inv_size});
        n1_p[2] = $signed(i_pos.pos_z) * $signed({1'b0, i_inv_size});
        n4_h    = r3_hx ^ r3_hy ^ r3_hz;
        n4_prod = {33'd0, n4_h} * {32'd0, RECIP};
        n5_rem  = r4_h - 32'(r4_q * 32'(TABLE_SETS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_p[k] <= n1_p[k][63:0];
        end
        // The upper word of a two's complement Q32.32 value is its floor.
        r2_key.x <= sat_index(r1_p[0][63:32]);
        r2_key.y <= sat_index(r1_p[1][63:32]);
        r2_key.z <= sat_index(r1_p[2][63:32]);

        r3_hx  <= {11'd0, r2_key.x} * HASH_X;
        r3_hy  <= {11'd0, r2_key.y} * HASH_Y;
        r3_hz  <= {11'd0, r2_key.z} * HASH_Z;
        r3_key <= r2_key;

        r4_h   <= n4_h;
        r4_q   <= 32'(n4_prod >> (32 + SET_W));
        r4_key <= r3_key;

        r5_set <= n5_rem[SET_W-1:0];
        r5_key <= r4_key;
    end

    assign o_valid = r5_valid;
    assign o_set   = r5_set;
    assign o_key   = r5_key;

endmodule

`default_nettype wire

// ----- rtl/core/vgpl_res_fifo.sv -----
// Result queue that decouples the table pipeline from the output channel.
`default_nettype none

module vgpl_res_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire vgpl_pkg::t_out_beat i_data,
    input  wire logic          i_pop,
    output logic               o_valid,
    output vgpl_pkg::t_out_beat o_data
);
    import vgpl_pkg::*;

    t_out_beat                 r_mem [RES_FIFO_DEPTH];
    logic [RES_FIFO_PTR_W-1:0] r_wr_ptr;
    logic [RES_FIFO_PTR_W-1:0] r_rd_ptr;
    logic [RES_FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/core/voxel_grid_point_limiter.sv -----
// Top level of the voxel grid point limiter: voxel table, update logic and ports.
//
//  Channel  | Direction | Handshake                  | Beat contents
//  ---------+-----------+----------------------------+--------------------------------
//  in       | input     | i_in_valid / o_in_ready    | t_in_beat: pos_x, pos_y, pos_z
//  out      | output    | o_out_valid / i_out_ready  | t_out_beat: keep, overflow, count
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// The block takes one point per cycle while o_in_ready is high. A point's result passes
// the front end registers and the update stage into the output queue; the rate is set
// by the single read-modify-write of one table row per cycle, with the last row written
// forwarded to the next point. After reset the count memory is cleared one row per cycle,
// every set once, and o_in_ready stays low meanwhile; configuration writes are taken as ever.
// Output stalls are absorbed by a sixteen-entry result queue; input beats are only
// accepted while every point in flight is sure of a queue slot.
`default_nettype none

module voxel_grid_point_limiter #(
    parameter int TABLE_SETS = 1024,
    parameter int TABLE_WAYS = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire vgpl_pkg::t_in_beat i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output vgpl_pkg::t_out_beat o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data
);
    import vgpl_pkg::*;

    localparam int SET_W = $clog2(TABLE_SETS);

    typedef logic [TABLE_WAYS-1:0][7:0] t_cnt_row;
    typedef t_voxel_key [TABLE_WAYS-1:0] t_key_row;

    // Configuration registers.
    logic [31:0] r_inv_size;
    logic [7:0]  r_max_pts;

    // Count memory clearing pass after reset.
    logic             r_clr_busy;
    logic [SET_W-1:0] r_clr_addr;

    // Flow control: beats accepted whose results are not yet delivered.
    logic [RES_FIFO_CNT_W-1:0] r_inflight;
    logic in_acc;
    logic out_pop;

    // Front end outputs: the point's set and key, ready for the table read.
    logic             f_valid;
    logic [SET_W-1:0] f_set;
    t_voxel_key       f_key;

    // Table memories, one row per set, and their registered read data.
    t_cnt_row r_cnt_mem [TABLE_SETS];
    t_key_row r_key_mem [TABLE_SETS];
    t_cnt_row r_cnt_rd;
    t_key_row r_key_rd;

    // Update stage.
    logic             r6_valid;
    logic [SET_W-1:0] r6_set;
    t_voxel_key       r6_key;

    // Last row written back, for forwarding to the point right behind it.
    logic             r_wb_valid;
    logic [SET_W-1:0] r_wb_set;
    t_cnt_row         r_wb_cnt;
    t_key_row         r_wb_key;

    t_cnt_row cur_cnt, n_cnt_row;
    t_key_row cur_key, n_key_row;
    logic [TABLE_WAYS-1:0] hit_oh, free_oh;
    logic      hit_found, free_found;
    logic [7:0] hit_cnt;
    t_out_beat res_beat;

    logic             cnt_we;
    logic [SET_W-1:0] cnt_waddr;
    t_cnt_row         cnt_wdata;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_in_ready  = !r_clr_busy && (r_inflight < RES_FIFO_CNT_W'(RES_FIFO_DEPTH));

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_size <= INV_VOXEL_SIZE_RST;
            r_max_pts  <= MAX_POINTS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INV_VOXEL_SIZE: r_inv_size <= i_cfg_data;
                CFG_MAX_POINTS:     r_max_pts  <= i_cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // The clearing pass walks every set once and then releases the input.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SET_W'(TABLE_SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({in_acc, out_pop})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    vgpl_front #(
        .TABLE_SETS (TABLE_SETS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_acc),
        .i_pos      (i_in_data),
        .i_inv_size (r_inv_size),
        .o_valid    (f_valid),
        .o_set      (f_set),
        .o_key      (f_key)
    );

    // Count memory: written by the clearing pass or by the update stage.
    assign cnt_we    = r_clr_busy || r6_valid;
    assign cnt_waddr = r_clr_busy ? r_clr_addr : r6_set;
    assign cnt_wdata = r_clr_busy ? '0 : n_cnt_row;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (f_valid) begin
            r_cnt_rd <= r_cnt_mem[f_set];
        end
    end

    // Key memory: keys are only ever compared behind a nonzero count.
    always_ff @(posedge i_clk) begin
        if (r6_valid) begin
            r_key_mem[r6_set] <= n_key_row;
        end
        if (f_valid) begin
            r_key_rd <= r_key_mem[f_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid   <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r6_valid   <= f_valid;
            r_wb_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_set   <= f_set;
        r6_key   <= f_key;
        r_wb_set <= r6_set;
        r_wb_cnt <= n_cnt_row;
        r_wb_key <= n_key_row;
    end

    // The row read in the cycle the previous point wrote it is stale; take the
    // written copy instead.
    always_comb begin
        if (r_wb_valid && (r_wb_set == r6_set)) begin
            cur_cnt = r_wb_cnt;
            cur_key = r_wb_key;
        end else begin
            cur_cnt = r_cnt_rd;
            cur_key = r_key_rd;
        end
    end

    // Find the lowest matching way and the lowest empty way.
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_oh     = '0;
        free_oh    = '0;
        hit_cnt    = '0;
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (cur_cnt[w] != 8'd0 && cur_key[w] == r6_key && !hit_found) begin
                hit_found = 1'b1;
                hit_oh[w] = 1'b1;
                hit_cnt   = cur_cnt[w];
            end
            if (cur_cnt[w] == 8'd0 && !free_found) begin
                free_found = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
    end

    // Decide the point's fate and build the rows to write back.
    always_comb begin
        n_cnt_row = cur_cnt;
        n_key_row = cur_key;
        res_beat  = '0;
        if (hit_found) begin
            if (hit_cnt < r_max_pts) begin
                res_beat.keep        = 1'b1;
                res_beat.voxel_count = hit_cnt + 8'd1;
                for (int w = 0; w < TABLE_WAYS; w++) begin
                    if (hit_oh[w]) begin
                        n_cnt_row[w] = hit_cnt + 8'd1;
                    end
                end
            end else begin
                res_beat.keep        = 1'b0;
                res_beat.voxel_count = hit_cnt;
            end
        end else if (free_found) begin
            // A new voxel is always kept, whatever the cap.
            res_beat.keep        = 1'b1;
            res_beat.voxel_count = 8'd1;
            for (int w = 0; w < TABLE_WAYS; w++) begin
                if (free_oh[w]) begin
                    n_cnt_row[w] = 8'd1;
                    n_key_row[w] = r6_key;
                end
            end
        end else begin
            // The set is full of other voxels: keep the point untracked.
            res_beat.keep           = 1'b1;
            res_beat.table_overflow = 1'b1;
            res_beat.voxel_count    = 8'd0;
        end
    end

    vgpl_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r6_valid),
        .i_data  (res_beat),
        .i_pop   (out_pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/vgpl_checker.sv -----
// Port-level assertions of the voxel grid point limiter and their binding.
`default_nettype none

module vgpl_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire vgpl_pkg::t_out_beat o_out_data
);
    import vgpl_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // The table is being cleared right after reset, so no point is taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("input ready during the clearing pass");

    // A dropped point belongs to a tracked voxel.
    a_drop_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.keep |->
            !o_out_data.table_overflow && (o_out_data.voxel_count != 8'd0))
        else $error("dropped point without a tracked voxel");

    // An overflowing point is kept and untracked.
    a_overflow_untracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.table_overflow |->
            o_out_data.keep && (o_out_data.voxel_count == 8'd0))
        else $error("overflow beat with a count or a drop");

endmodule

bind voxel_grid_point_limiter vgpl_checker u_vgpl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- verif/vgpl_point_tracker_pkg.sv -----
// Voxel table tracker that predicts the limiter's decision for every accepted point.
package vgpl_point_tracker_pkg;
    import vgpl_pkg::*;

    localparam int SETS = 1024;
    localparam int WAYS = 4;

    localparam logic [31:0] MIX_X = 32'd73856093;
    localparam logic [31:0] MIX_Y = 32'd19349663;
    localparam logic [31:0] MIX_Z = 32'd83492791;

    localparam logic signed [63:0] VOXEL_HI = 64'sd1048575;
    localparam logic signed [63:0] VOXEL_LO = -64'sd1048576;

    // A register index that maps to nothing; writes to it must be ignored.
    localparam logic [7:0] CFG_SPARE = 8'hFF;

    localparam int NOISY_LIMIT = 30;

    class point_limit_tracker;
        logic [31:0] inv_size;
        logic [7:0]  cap;
        logic [62:0] keys [SETS * WAYS];
        logic [7:0]  counts [SETS * WAYS];
        t_out_beat   pending_decisions [$];
        int          errors;
        int          decisions;

        function new();
            inv_size  = INV_VOXEL_SIZE_RST;
            cap       = MAX_POINTS_RST;
            errors    = 0;
            decisions = 0;
            foreach (counts[i]) begin
                counts[i] = 8'd0;
                keys[i]   = 63'd0;
            end
        endfunction

        function void apply_reg(logic [7:0] idx, logic [31:0] data);
            case (idx)
                CFG_INV_VOXEL_SIZE: inv_size = data;
                CFG_MAX_POINTS:     cap      = data[7:0];
                default: ;
            endcase
        endfunction

        // Floor of coord times the inverse size, taken as an exact Q32.32 product.
        function logic [20:0] voxel_index(logic [31:0] coord);
            logic signed [63:0] scaled;
            logic signed [63:0] idx;
            scaled = $signed({{32{coord[31]}}, coord}) * $signed({32'd0, inv_size});
            idx = scaled >>> 32;
            if (idx > VOXEL_HI) idx = VOXEL_HI;
            else if (idx < VOXEL_LO) idx = VOXEL_LO;
            return idx[20:0];
        endfunction

        function t_voxel_key key_of(t_in_beat p);
            t_voxel_key k;
            k.x = voxel_index(p.pos_x);
            k.y = voxel_index(p.pos_y);
            k.z = voxel_index(p.pos_z);
            return k;
        endfunction

        function int unsigned set_of(t_voxel_key k);
            logic [31:0] h;
            h = ({11'd0, k.x} * MIX_X) ^ ({11'd0, k.y} * MIX_Y) ^ ({11'd0, k.z} * MIX_Z);
            return h % SETS;
        endfunction

        function void note_point(t_in_beat p);
            t_voxel_key k;
            t_out_beat  r;
            int         base;
            int         free_way;
            int         e;
            bit         found;
            k        = key_of(p);
            base     = set_of(k) * WAYS;
            free_way = -1;
            found    = 1'b0;
            r        = '0;
            for (int w = 0; w < WAYS; w++) begin
                e = base + w;
                if (counts[e] == 8'd0) begin
                    if (free_way < 0) free_way = w;
                end else if (!found && keys[e] == k) begin
                    found = 1'b1;
                    if (counts[e] < cap) begin
                        counts[e] = counts[e] + 8'd1;
                        r.keep = 1'b1;
                    end else begin
                        r.keep = 1'b0;
                    end
                    r.voxel_count = counts[e];
                end
            end
            if (!found) begin
                r.keep = 1'b1;
                if (free_way >= 0) begin
                    keys[base + free_way]   = k;
                    counts[base + free_way] = 8'd1;
                    r.voxel_count = 8'd1;
                end else begin
                    r.table_overflow = 1'b1;
                end
            end
            pending_decisions.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= NOISY_LIMIT) $display("MISMATCH %s", msg);
        endtask

        task check_decision(t_out_beat got);
            t_out_beat want;
            decisions++;
            if (pending_decisions.size() == 0) begin
                report($sformatf("decision %0d arrived with none pending", decisions));
                return;
            end
            want = pending_decisions.pop_front();
            if (got.keep !== want.keep)
                report($sformatf("decision %0d keep %0b, expected %0b",
                                 decisions, got.keep, want.keep));
            if (got.table_overflow !== want.table_overflow)
                report($sformatf("decision %0d table_overflow %0b, expected %0b",
                                 decisions, got.table_overflow, want.table_overflow));
            if (got.voxel_count !== want.voxel_count)
                report($sformatf("decision %0d voxel_count %0d, expected %0d",
                                 decisions, got.voxel_count, want.voxel_count));
        endtask

        function int pending_count();
            return pending_decisions.size();
        endfunction
    endclass

endpackage

// ----- verif/tb.sv -----
// Self-checking testbench of the voxel grid point limiter with random flow control.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vgpl_pkg::*;
    import vgpl_point_tracker_pkg::*;

    // The slowest correct run is roughly 1800 beats, each with its idle input gap, its
    // output stalls and the pipeline latency, plus the table clear after reset, the
    // long output hold and the drains between phases.
    localparam int LIMIT_CYCLES = 400000;
    // Once nothing is pending, watch the output a while longer for stray beats.
    localparam int TAIL_CYCLES  = 40;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    t_in_beat    in_data    = '0;
    logic        out_ready  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [7:0]  cfg_index  = CFG_INV_VOXEL_SIZE;
    logic [31:0] cfg_data   = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_beat   o_out_data;
    logic        o_cfg_ready;

    point_limit_tracker tracker;

    // Recently accepted points; revisiting them drives voxel counts up to the cap.
    t_in_beat    recent [$];
    // Sets that the current phase deliberately crowds so that they overflow.
    int unsigned crowded_sets [3];

    // Flow control shared with the output side. Only the main sequence writes
    // hold_asked and calm; the output process owns its own counters.
    int          hold_asked = 0;
    bit          hold_taken = 1'b0;
    int          hold_left  = 0;
    int          stall_left = 0;
    bit          calm       = 1'b0;
    int          cycle_count = 0;

    voxel_grid_point_limiter #(
        .TABLE_SETS(SETS),
        .TABLE_WAYS(WAYS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Output side. Every beat taken at an edge is checked against the oldest pending
    // decision. Ready then drops in random bursts, except during the one long hold that
    // backs the block up into its input, and in the calm final phase.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            tracker.check_decision(o_out_data);
        end
        if (!hold_taken && hold_asked > 0) begin
            hold_left  = hold_asked;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_beat point_at(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
        t_in_beat p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        return p;
    endfunction

    // Coordinates at the ends of the Q16.16 range and around zero.
    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'hFFFF_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0000;
            5: return 32'h0000_0001;
            6: return 32'h0001_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Random points until one hashes into the wanted set. With a tiny inverse size
    // every point lands in a handful of voxels, so the search may give up; the last
    // candidate is then just another random point.
    function automatic t_in_beat find_in_set(input int unsigned target, input int tries);
        t_in_beat p;
        for (int i = 0; i < tries; i++) begin
            p = point_at($urandom(), $urandom(), $urandom());
            if (tracker.set_of(tracker.key_of(p)) == target) return p;
        end
        return p;
    endfunction

    // Mix of random points: revisits of known voxels, a dense local cloud, points aimed
    // at crowded sets, full-range coordinates and range extremes.
    function automatic t_in_beat pick_point(input int span);
        t_in_beat p;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && recent.size() > 0) begin
            p = recent[$urandom_range(0, recent.size() - 1)];
            if ($urandom_range(0, 1) == 1) p.pos_z[3:0] = 4'($urandom());
        end else if (roll < 60) begin
            p.pos_x = int'($urandom_range(0, 2 * span)) - span;
            p.pos_y = int'($urandom_range(0, 2 * span)) - span;
            p.pos_z = int'($urandom_range(0, 2 * span)) - span;
        end else if (roll < 75) begin
            p = find_in_set(crowded_sets[$urandom_range(0, 2)], 4000);
        end else if (roll < 90) begin
            p = point_at($urandom(), $urandom(), $urandom());
        end else begin
            p = point_at(edge_coord(), edge_coord(), edge_coord());
        end
        return p;
    endfunction

    // Offers one point and waits for its beat to be taken. Valid stays high afterwards
    // so back-to-back beats are possible; after a beat, a random gap may lower it.
    task automatic offer_point(input t_in_beat p);
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        tracker.note_point(p);
        if (recent.size() >= 64) void'(recent.pop_front());
        recent.push_back(p);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Stops offering points and waits until every pending decision has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge clk);
    endtask

    // One register write; cfg_valid is left high so writes can follow back to back.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        tracker.apply_reg(idx, data);
    endtask

    // Writes both registers plus a write to an unmapped index, which must change
    // nothing. The cap write carries random upper bits that must be ignored.
    task automatic set_phase(input logic [31:0] inv, input logic [7:0] cap);
        logic [31:0] noise;
        noise = $urandom();
        write_reg(CFG_INV_VOXEL_SIZE, inv);
        write_reg(CFG_SPARE, $urandom());
        write_reg(CFG_MAX_POINTS, {noise[31:8], cap});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] inv, input logic [7:0] cap, input int count,
                             input int span, input int hold);
        set_phase(inv, cap);
        foreach (crowded_sets[i]) crowded_sets[i] = $urandom_range(0, SETS - 1);
        for (int i = 0; i < count; i++) begin
            if (i == 20 && hold > 0) hold_asked = hold;
            offer_point(pick_point(span));
        end
        wait_for_results();
    endtask

    // Directed beats under the reset settings: ten voxels per metre, one point per voxel.
    task automatic run_directed();
        t_in_beat    crowd [6];
        int unsigned target;
        // A new voxel is kept, then the same voxel is at its cap and drops points,
        // including a point a tiny step away that still rounds into voxel zero.
        offer_point(point_at(32'h0, 32'h0, 32'h0));
        offer_point(point_at(32'h0, 32'h0, 32'h0));
        offer_point(point_at(32'h1, 32'h1, 32'h1));
        // The smallest negative step floors to index minus one, not zero.
        offer_point(point_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Range extremes give the outermost indices, which stay inside the 21-bit limits.
        offer_point(point_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        offer_point(point_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        offer_point(point_at(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        offer_point(point_at(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // Six distinct voxels in one set: four ways fill, the rest overflow and are
        // kept untracked. Then a tracked voxel is revisited and an overflowed one again.
        crowd[0] = point_at(32'h0005_0000, 32'h0003_0000, $urandom());
        target   = tracker.set_of(tracker.key_of(crowd[0]));
        for (int i = 1; i < 6; i++) crowd[i] = find_in_set(target, 40000);
        for (int i = 0; i < 6; i++) offer_point(crowd[i]);
        offer_point(crowd[0]);
        offer_point(crowd[5]);
    endtask

    initial begin
        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its table after reset and holds off input meanwhile;
        // the first beat simply waits for ready.
        run_directed();
        wait_for_results();

        // One metre voxels with a cap of three, then the cap lowered under the
        // counts already stored for the same voxels.
        run_phase(32'd65536, 8'd3, 300, 3 * 65536, 0);
        run_phase(32'd65536, 8'd1, 150, 3 * 65536, 0);
        // Largest inverse size and largest cap; the output is held for a long
        // stretch so the result queue fills and the input stalls.
        run_phase(32'hFFFF_FFFF, 8'd255, 250, 6, 400);
        // Zero inverse size folds every point into one voxel, which fills to 255.
        run_phase(32'd0, 8'd255, 270, 1000, 0);
        // Smallest inverse size: only a handful of voxels exist.
        run_phase(32'd1, 8'd2, 80, 1 << 29, 0);
        // Cap of zero: new voxels still keep their first point, nothing more.
        run_phase(32'd4096, 8'd0, 200, 3 << 20, 0);
        run_phase($urandom(), 8'($urandom_range(0, 255)), 300,
                  $urandom_range(1, 1 << 22), 0);
        // Final phase at full rate on both sides.
        calm = 1'b1;
        run_phase(32'd65536, 8'd5, 250, 2 * 65536, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_count() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
